// ===== sv/dry_wet_mixer_with_latency_delay_core_macros.svh =====
// Assertion macros for the dry/wet mixer checker.
// Each macro expects clk to be visible where it is used, and DWM_ASSERT also expects rst_n.
`ifndef DRY_WET_MIXER_WITH_LATENCY_DELAY_CORE_MACROS_SVH
`define DRY_WET_MIXER_WITH_LATENCY_DELAY_CORE_MACROS_SVH

// Checked only while the block is out of reset.
`define DWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define DWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dwm_pkg.sv =====
// Shared types and constants of the dry/wet mixer.
// No dependencies; used by the interfaces and the core.
`timescale 1ns / 1ps
`default_nettype none

package dwm_pkg;

    localparam int CHANNEL_W   = 3;
    localparam int DELAY_W     = 10;
    localparam int MIX_W       = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DELAY_LENGTH = 1'b0,
        REG_WET_MIX      = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_MIX   = 1'b0,
        MODE_LATCH = 1'b1
    } mode_t;

endpackage

`default_nettype wire

// ===== sv/dwm_item_if.sv =====
// Input item channel of the dry/wet mixer.
// Depends on dwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dwm_item_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                                valid;
    logic                                ready;
    logic                                mode;
    logic [dwm_pkg::CHANNEL_W-1:0]       channel;
    logic signed [SAMPLE_BITS-1:0]       dry_data;
    logic signed [SAMPLE_BITS-1:0]       wet_data;
    logic                                wet_present;

    modport source (
        output valid, mode, channel, dry_data, wet_data, wet_present,
        input  ready
    );

    modport sink (
        input  valid, mode, channel, dry_data, wet_data, wet_present,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/dwm_result_if.sv =====
// Result item channel of the dry/wet mixer.
// Depends on dwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dwm_result_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                                valid;
    logic                                ready;
    logic signed [SAMPLE_BITS-1:0]       mixed_sample;
    logic [dwm_pkg::CHANNEL_W-1:0]       out_channel;

    modport source (
        output valid, mixed_sample, out_channel,
        input  ready
    );

    modport sink (
        input  valid, mixed_sample, out_channel,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/dwm_cfg_if.sv =====
// Configuration write channel of the dry/wet mixer.
// Depends on dwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dwm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dwm_pkg::CFG_INDEX_W-1:0]     index;
    logic [dwm_pkg::CFG_DATA_W-1:0]      data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/dry_wet_mixer_with_latency_delay_core.sv =====
// Multichannel dry/wet crossfade mixer with a per-channel dry delay ring.
// Depends on dwm_pkg, dwm_item_if, dwm_result_if and dwm_cfg_if.
//
// The block takes one item per clock cycle when not stalled. Each accepted mix item passes
// through the registered read of the dry delay memory, then registers for the difference,
// the multiply by the wet proportion, and the shift and saturation.
// The delay memory has one write and one read port, so throughput stays at one item per
// cycle; input ready falls only when the output register holds a result that is not taken
// and every stage behind it is full. The memory needs no clearing pass after reset or after
// a delay write: a per-channel write position and wrap flag mark entries not yet written,
// and those read as zero.
`timescale 1ns / 1ps
`default_nettype none

module dry_wet_mixer_with_latency_delay_core #(
    parameter int CHANNELS    = 8,
    parameter int DELAY_DEPTH = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    dwm_item_if.sink          mix_req,
    dwm_result_if.source      mix_rsp,
    dwm_cfg_if.sink           cfg
);

    localparam int FIELD_CH  = 1 << dwm_pkg::CHANNEL_W;
    localparam int USED_CH   = (CHANNELS < FIELD_CH) ? CHANNELS : FIELD_CH;
    localparam int CH_W      = (USED_CH > 1) ? $clog2(USED_CH) : 1;
    localparam int PW        = $clog2(DELAY_DEPTH);
    localparam int MEM_DEPTH = USED_CH * DELAY_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMP_W     = (PW > dwm_pkg::DELAY_W) ? PW : dwm_pkg::DELAY_W;
    localparam int SB        = SAMPLE_BITS;
    localparam int PROD_W    = SB + 18;
    localparam int SUM_W     = PROD_W + 1;
    localparam int SHR_W     = SUM_W - 16;

    localparam logic [PW-1:0] DEPTH_LAST = PW'(DELAY_DEPTH - 1);

    // Configuration and per-channel state
    logic [PW-1:0]                   delay_reg;
    logic [dwm_pkg::MIX_W-1:0]       wet_mix_reg;
    logic [PW-1:0]                   wp_reg      [USED_CH];
    logic                            wrapped_reg [USED_CH];
    logic signed [SB-1:0]            held_wet_reg [USED_CH];

    // Delay memory
    logic signed [SB-1:0]            mem [MEM_DEPTH];
    logic signed [SB-1:0]            rd_data_reg;

    // Pipeline
    logic                            s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic                            s1_ready, s2_ready, s3_ready, out_ready;
    logic [dwm_pkg::CHANNEL_W-1:0]   s1_ch_reg, s2_ch_reg, s3_ch_reg, out_ch_reg;
    logic signed [SB-1:0]            s1_dry_reg, s1_wet_reg, s2_dry_reg, s3_dry_reg;
    logic                            s1_fwd_reg, s1_hit_reg;
    logic signed [SB:0]              s2_diff_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [SB-1:0]            out_sample_reg;

    // Input side decode
    logic                            req_fire, ch_ok, mix_go, latch_go;
    logic [CH_W-1:0]                 ch_idx;
    logic [PW-1:0]                   wp_cur, rp, wp_next;
    logic                            rd_hit, fwd;
    logic [ADDR_W-1:0]               ch_base, waddr, raddr;
    logic signed [SB-1:0]            wet_pick;
    logic [CMP_W-1:0]                delay_cmp;
    logic [PW-1:0]                   delay_eff;
    logic [dwm_pkg::MIX_W-1:0]       mix_clamped;

    // Datapath
    logic signed [SB-1:0]            dry_sel;
    logic signed [SB:0]              diff_next;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [SUM_W-1:0]         sum;
    logic signed [SHR_W-1:0]         shifted;
    logic [SHR_W-SB:0]               top_bits;
    logic signed [SB-1:0]            sat_next;

    assign out_ready = !out_valid_reg || mix_rsp.ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign mix_req.ready = s1_ready;
    assign cfg.ready     = 1'b1;

    assign req_fire = mix_req.valid && s1_ready;
    assign ch_ok    = (4'(mix_req.channel) < 4'(USED_CH));
    assign mix_go   = req_fire && ch_ok && (mix_req.mode == dwm_pkg::MODE_MIX);
    assign latch_go = req_fire && ch_ok && (mix_req.mode == dwm_pkg::MODE_LATCH);
    assign ch_idx   = mix_req.channel[CH_W-1:0];

    always_comb
    begin
        wp_cur = wp_reg[ch_idx];
        if (wp_cur >= delay_reg)
        begin
            rp = wp_cur - delay_reg;
        end
        else
        begin
            rp = PW'((PW+1)'(wp_cur) + (PW+1)'(DELAY_DEPTH) - (PW+1)'(delay_reg));
        end
        rd_hit   = wrapped_reg[ch_idx] || (delay_reg <= wp_cur);
        fwd      = (delay_reg == '0);
        wp_next  = (wp_cur == DEPTH_LAST) ? '0 : wp_cur + PW'(1);
        ch_base  = ADDR_W'(ch_idx) * ADDR_W'(DELAY_DEPTH);
        waddr    = ch_base + ADDR_W'(wp_cur);
        raddr    = ch_base + ADDR_W'(rp);
        wet_pick = mix_req.wet_present ? mix_req.wet_data : held_wet_reg[ch_idx];
    end

    always_comb
    begin
        delay_cmp = CMP_W'(cfg.data[dwm_pkg::DELAY_W-1:0]);
        if (delay_cmp >= CMP_W'(DELAY_DEPTH - 1))
        begin
            delay_eff = DEPTH_LAST;
        end
        else
        begin
            delay_eff = PW'(delay_cmp);
        end
        mix_clamped = (cfg.data > dwm_pkg::MIX_ONE) ? dwm_pkg::MIX_ONE : cfg.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg   <= '0;
            wet_mix_reg <= dwm_pkg::MIX_ONE;
            for (int i = 0; i < USED_CH; i++)
            begin
                wp_reg[i]       <= '0;
                wrapped_reg[i]  <= 1'b0;
                held_wet_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg.valid && (cfg.index == dwm_pkg::REG_DELAY_LENGTH))
            begin
                delay_reg <= delay_eff;
                for (int i = 0; i < USED_CH; i++)
                begin
                    wp_reg[i]      <= '0;
                    wrapped_reg[i] <= 1'b0;
                end
            end
            else if (mix_go)
            begin
                wp_reg[ch_idx] <= wp_next;
                if (wp_cur == DEPTH_LAST)
                begin
                    wrapped_reg[ch_idx] <= 1'b1;
                end
            end
            if (cfg.valid && (cfg.index == dwm_pkg::REG_WET_MIX))
            begin
                wet_mix_reg <= mix_clamped;
            end
            if (latch_go)
            begin
                held_wet_reg[ch_idx] <= mix_req.wet_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mix_go)
        begin
            mem[waddr] <= mix_req.dry_data;
        end
        if (s1_ready)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            dry_sel = s1_dry_reg;
        end
        else if (s1_hit_reg)
        begin
            dry_sel = rd_data_reg;
        end
        else
        begin
            dry_sel = '0;
        end
        diff_next = (SB+1)'(s1_wet_reg) - (SB+1)'(dry_sel);
        prod_next = PROD_W'($signed({1'b0, wet_mix_reg})) * PROD_W'(s2_diff_reg);
        sum       = SUM_W'(prod_reg) + (SUM_W'(s3_dry_reg) <<< 16);
        shifted   = sum[SUM_W-1:16];
        top_bits  = shifted[SHR_W-1:SB-1];
        if ((&top_bits) || (~|top_bits))
        begin
            sat_next = shifted[SB-1:0];
        end
        else if (shifted[SHR_W-1])
        begin
            sat_next = {1'b1, {(SB-1){1'b0}}};
        end
        else
        begin
            sat_next = {1'b0, {(SB-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= mix_go;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_ch_reg  <= mix_req.channel;
            s1_dry_reg <= mix_req.dry_data;
            s1_wet_reg <= wet_pick;
            s1_fwd_reg <= fwd;
            s1_hit_reg <= rd_hit;
        end
        if (s2_ready)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_dry_reg  <= dry_sel;
            s2_diff_reg <= diff_next;
        end
        if (s3_ready)
        begin
            s3_ch_reg  <= s2_ch_reg;
            s3_dry_reg <= s2_dry_reg;
            prod_reg   <= prod_next;
        end
        if (out_ready)
        begin
            out_ch_reg     <= s3_ch_reg;
            out_sample_reg <= sat_next;
        end
    end

    assign mix_rsp.valid        = out_valid_reg;
    assign mix_rsp.mixed_sample = out_sample_reg;
    assign mix_rsp.out_channel  = out_ch_reg;

endmodule

`default_nettype wire

// ===== sv/dwm_checker.sv =====
// Port-level assertions for the dry/wet mixer core, with the bind that attaches them.
// Depends on dwm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "dry_wet_mixer_with_latency_delay_core_macros.svh"

module dwm_checker #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 24
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_valid,
    input logic                              req_ready,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic signed [SAMPLE_BITS-1:0]     rsp_sample,
    input logic [dwm_pkg::CHANNEL_W-1:0]     rsp_channel
);

    // A result that is not taken keeps its value.
    `DWM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample), "result changed while stalled")

    // Reset empties the output register by the next clock edge.
    `DWM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !rsp_valid, "result shown during reset")

    // With the output register empty, nothing can hold up the input side.
    `DWM_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "input stalled with empty output")

    // Items for channels beyond the configured count never produce a result.
    `DWM_ASSERT(a_rsp_channel, rsp_valid |-> (int'(rsp_channel) < CHANNELS), "result for unused channel")

    // An input item offered while the block is idle is taken in that cycle.
    `DWM_ASSERT(a_take_when_idle, req_valid && !rsp_valid |-> req_ready, "offered item not taken")

endmodule

bind dry_wet_mixer_with_latency_delay_core dwm_checker #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dwm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (mix_req.valid),
    .req_ready   (mix_req.ready),
    .rsp_valid   (mix_rsp.valid),
    .rsp_ready   (mix_rsp.ready),
    .rsp_sample  (mix_rsp.mixed_sample),
    .rsp_channel (mix_rsp.out_channel)
);

`default_nettype wire

// ===== tb/dry_wet_mixer_with_latency_delay_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the dry/wet mixer core: a directed table, then random phases.
// Results are compared with known table values or an in-bench ring and crossfade predictor.
// Depends on dwm_pkg, the three channel interfaces and dry_wet_mixer_with_latency_delay_core.

module dry_wet_mixer_with_latency_delay_core_test;

    localparam int CHANNELS     = 8;
    localparam int DELAY_DEPTH  = 1024;
    localparam int SAMPLE_BITS  = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 110;
    localparam int CFG_W        = dwm_pkg::CFG_DATA_W;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t S_MAX  = 24'sh7FFFFF;
    localparam sample_t S_MIN  = 24'sh800000;
    localparam sample_t S_ZERO = 24'sh000000;

    typedef struct {
        dwm_pkg::mode_t                mode;
        logic [dwm_pkg::CHANNEL_W-1:0] channel;
        sample_t                       dry;
        sample_t                       wet;
        logic                          present;
    } mix_item_t;

    typedef struct {
        sample_t                       sample;
        logic [dwm_pkg::CHANNEL_W-1:0] channel;
    } mix_out_t;

    typedef enum {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        mix_item_t             item;
        bit                    known;
        sample_t               known_out;
        dwm_pkg::cfg_reg_t     reg_sel;
        logic [CFG_W-1:0]      reg_value;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dwm_item_if #(.SAMPLE_BITS(SAMPLE_BITS))   mix_req ();
    dwm_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) mix_rsp ();
    dwm_cfg_if                                 cfg_bus ();

    dry_wet_mixer_with_latency_delay_core #(
        .CHANNELS    (CHANNELS),
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .mix_req (mix_req),
        .mix_rsp (mix_rsp),
        .cfg     (cfg_bus)
    );

    sample_t                      dry_ring [CHANNELS][DELAY_DEPTH];
    logic [dwm_pkg::DELAY_W-1:0]  ring_pos [CHANNELS];
    sample_t                      wet_hold [CHANNELS];
    logic [dwm_pkg::DELAY_W-1:0]  cur_delay;
    logic [dwm_pkg::MIX_W-1:0]    cur_mix;

    mix_out_t  pending_mixes [$];
    stim_row_t stim_table [$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    bit        pressure_go = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("dry_wet_mixer_with_latency_delay_core_test NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    task automatic clear_ring();
        foreach (dry_ring[c, k])
            dry_ring[c][k] = S_ZERO;
        foreach (ring_pos[c])
            ring_pos[c] = '0;
    endtask

    task automatic predict_mix(input mix_item_t it, output bit gives, output mix_out_t res);
        logic [dwm_pkg::DELAY_W-1:0] wp;
        logic [dwm_pkg::DELAY_W-1:0] rp;
        longint                      dry_l;
        longint                      wet_l;
        longint                      mix_l;
        longint                      acc;
        gives = 1'b0;
        res.sample = S_ZERO;
        res.channel = it.channel;
        if (it.mode == dwm_pkg::MODE_LATCH)
        begin
            wet_hold[it.channel] = it.wet;
            return;
        end
        wp = ring_pos[it.channel];
        dry_ring[it.channel][wp] = it.dry;
        rp = wp - cur_delay;
        dry_l = longint'(dry_ring[it.channel][rp]);
        ring_pos[it.channel] = wp + 1'b1;
        wet_l = it.present ? longint'(it.wet) : longint'(wet_hold[it.channel]);
        mix_l = longint'(cur_mix);
        acc = (longint'(dwm_pkg::MIX_ONE) - mix_l) * dry_l + mix_l * wet_l;
        acc = acc >>> 16;
        if (acc > longint'(S_MAX))
            acc = longint'(S_MAX);
        else if (acc < longint'(S_MIN))
            acc = longint'(S_MIN);
        res.sample = acc[SAMPLE_BITS-1:0];
        gives = 1'b1;
    endtask

    // Called at a rising edge with the item channel idle or about to be lowered.
    task automatic apply_write(input dwm_pkg::cfg_reg_t sel, input logic [CFG_W-1:0] value);
        mix_req.valid <= 1'b0;
        burst_left = 0;
        while (pending_mixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= sel;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (sel == dwm_pkg::REG_DELAY_LENGTH)
        begin
            cur_delay = value[dwm_pkg::DELAY_W-1:0];
            clear_ring();
        end
        else
        begin
            cur_mix = (value > CFG_W'(dwm_pkg::MIX_ONE)) ? dwm_pkg::MIX_ONE
                                                         : value[dwm_pkg::MIX_W-1:0];
        end
    endtask

    task automatic offer_item(input mix_item_t it, input bit known, input sample_t known_out);
        int       gap;
        bit       gives;
        mix_out_t res;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                mix_req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        mix_req.mode        <= it.mode;
        mix_req.channel     <= it.channel;
        mix_req.dry_data    <= it.dry;
        mix_req.wet_data    <= it.wet;
        mix_req.wet_present <= it.present;
        mix_req.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!mix_req.ready);
        predict_mix(it, gives, res);
        if (gives)
        begin
            if (known)
                res.sample = known_out;
            pending_mixes.push_back(res);
        end
    endtask

    function automatic sample_t random_sample();
        logic [31:0] r;
        r = $urandom();
        case (r[3:0])
            4'd0:    return S_MAX;
            4'd1:    return S_MIN;
            4'd2:    return S_ZERO;
            default:
            begin
                r = $urandom();
                return r[SAMPLE_BITS-1:0];
            end
        endcase
    endfunction

    function automatic mix_item_t random_item();
        mix_item_t   it;
        logic [31:0] r;
        r = $urandom();
        it.mode    = (r[2:0] == 3'd0 || r[2:0] == 3'd1) ? dwm_pkg::MODE_LATCH
                                                         : dwm_pkg::MODE_MIX;
        it.channel = r[5:3];
        it.present = r[6] | r[7];
        it.dry     = random_sample();
        it.wet     = random_sample();
        return it;
    endfunction

    function automatic void add_item(input dwm_pkg::mode_t m,
                                     input logic [dwm_pkg::CHANNEL_W-1:0] ch,
                                     input sample_t dry, input sample_t wet,
                                     input logic present, input bit known,
                                     input sample_t want);
        stim_row_t row;
        row.kind         = ROW_ITEM;
        row.item.mode    = m;
        row.item.channel = ch;
        row.item.dry     = dry;
        row.item.wet     = wet;
        row.item.present = present;
        row.known        = known;
        row.known_out    = want;
        row.reg_sel      = dwm_pkg::REG_DELAY_LENGTH;
        row.reg_value    = '0;
        stim_table.push_back(row);
    endfunction

    function automatic void add_write(input dwm_pkg::cfg_reg_t sel,
                                      input logic [CFG_W-1:0] value);
        stim_row_t row;
        row.kind         = ROW_WRITE;
        row.item.mode    = dwm_pkg::MODE_MIX;
        row.item.channel = '0;
        row.item.dry     = S_ZERO;
        row.item.wet     = S_ZERO;
        row.item.present = 1'b0;
        row.known        = 1'b0;
        row.known_out    = S_ZERO;
        row.reg_sel      = sel;
        row.reg_value    = value;
        stim_table.push_back(row);
    endfunction

    always @(posedge clk)
    begin
        mix_out_t want;
        if (rst_n && mix_rsp.valid && mix_rsp.ready)
        begin
            if (pending_mixes.size() == 0)
            begin
                report_mismatch("result with nothing pending", 0, longint'(mix_rsp.mixed_sample));
            end
            else
            begin
                want = pending_mixes.pop_front();
                if (mix_rsp.mixed_sample !== want.sample)
                    report_mismatch("mixed_sample", longint'(want.sample),
                                    longint'(mix_rsp.mixed_sample));
                if (mix_rsp.out_channel !== want.channel)
                    report_mismatch("out_channel", longint'(want.channel),
                                    longint'(mix_rsp.out_channel));
            end
        end
    end

    initial
    begin
        int  pattern;
        int  pattern_left;
        int  hold_left;
        bit  hold_done;
        pattern = 0;
        pattern_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        mix_rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pressure_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                mix_rsp.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = $urandom_range(0, 2);
                    pattern_left = $urandom_range(5, 60);
                end
                pattern_left--;
                case (pattern)
                    0:       mix_rsp.ready <= 1'b1;
                    1:       mix_rsp.ready <= ($urandom_range(0, 3) != 0);
                    default: mix_rsp.ready <= ($urandom_range(0, 1) != 0);
                endcase
            end
        end
    end

    initial
    begin
        logic [31:0] r;
        logic [CFG_W-1:0] value;
        mix_req.valid       = 1'b0;
        mix_req.mode        = dwm_pkg::MODE_MIX;
        mix_req.channel     = '0;
        mix_req.dry_data    = S_ZERO;
        mix_req.wet_data    = S_ZERO;
        mix_req.wet_present = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = dwm_pkg::REG_DELAY_LENGTH;
        cfg_bus.data        = '0;
        cur_delay = '0;
        cur_mix   = dwm_pkg::MIX_ONE;
        clear_ring();
        foreach (wet_hold[c])
            wet_hold[c] = S_ZERO;

        // After reset the mix is fully wet and the dry path has no delay.
        add_item(dwm_pkg::MODE_MIX,   3'd0, S_ZERO,  S_MAX,  1'b1, 1'b1, S_MAX);
        add_item(dwm_pkg::MODE_MIX,   3'd1, -24'sd1, S_MIN,  1'b1, 1'b1, S_MIN);
        add_item(dwm_pkg::MODE_MIX,   3'd2, S_MAX,   24'sd5, 1'b0, 1'b1, S_ZERO);
        add_item(dwm_pkg::MODE_LATCH, 3'd7, S_MIN,   S_MAX,  1'b1, 1'b0, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd7, S_ZERO,  S_ZERO, 1'b0, 1'b1, S_MAX);
        add_item(dwm_pkg::MODE_LATCH, 3'd3, S_MAX,   S_MIN,  1'b0, 1'b0, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd3, S_MAX,   S_MAX,  1'b0, 1'b1, S_MIN);
        add_write(dwm_pkg::REG_WET_MIX, 17'd0);
        add_item(dwm_pkg::MODE_MIX,   3'd4, S_MAX,   S_MIN,  1'b1, 1'b1, S_MAX);
        add_item(dwm_pkg::MODE_MIX,   3'd5, S_MIN,   S_MAX,  1'b1, 1'b1, S_MIN);
        add_item(dwm_pkg::MODE_MIX,   3'd6, 24'sh5A5A5A, 24'shA5A5A5, 1'b1, 1'b0, S_ZERO);
        // Writes above one are clamped to fully wet.
        add_write(dwm_pkg::REG_WET_MIX, 17'h1FFFF);
        add_item(dwm_pkg::MODE_MIX,   3'd0, 24'sd1,  S_MIN,  1'b1, 1'b1, S_MIN);
        add_write(dwm_pkg::REG_WET_MIX, 17'd32768);
        add_item(dwm_pkg::MODE_MIX,   3'd1, S_MAX,   S_MIN,  1'b1, 1'b0, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd2, -24'sd1, S_ZERO, 1'b1, 1'b0, S_ZERO);
        // A delay write empties the rings, so the first reads come back as zero.
        add_write(dwm_pkg::REG_DELAY_LENGTH, 17'd2);
        add_write(dwm_pkg::REG_WET_MIX, 17'd0);
        add_item(dwm_pkg::MODE_MIX,   3'd5, 24'sd100, S_MAX, 1'b1, 1'b1, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd5, 24'sd200, S_MAX, 1'b1, 1'b1, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd5, 24'sd300, S_MIN, 1'b0, 1'b1, 24'sd100);
        add_item(dwm_pkg::MODE_MIX,   3'd5, 24'sd400, S_MIN, 1'b1, 1'b1, 24'sd200);
        add_write(dwm_pkg::REG_DELAY_LENGTH, 17'd1023);
        add_item(dwm_pkg::MODE_MIX,   3'd6, 24'sd7,  S_MAX,  1'b1, 1'b1, S_ZERO);
        add_item(dwm_pkg::MODE_LATCH, 3'd6, S_ZERO,  24'sd9, 1'b1, 1'b0, S_ZERO);
        add_item(dwm_pkg::MODE_MIX,   3'd6, S_MIN,   S_ZERO, 1'b0, 1'b0, S_ZERO);
        add_write(dwm_pkg::REG_DELAY_LENGTH, 17'd0);
        add_item(dwm_pkg::MODE_MIX,   3'd0, -24'sd5, S_MAX,  1'b1, 1'b1, -24'sd5);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_WRITE)
                apply_write(stim_table[i].reg_sel, stim_table[i].reg_value);
            else
                offer_item(stim_table[i].item, stim_table[i].known, stim_table[i].known_out);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            r = $urandom();
            case (r[2:0])
                3'd0:    value = 17'd0;
                3'd1:    value = 17'd1023;
                3'd2:    value = 17'd1;
                default: value = CFG_W'($urandom_range(2, 24));
            endcase
            apply_write(dwm_pkg::REG_DELAY_LENGTH, value);
            r = $urandom();
            case (r[2:0])
                3'd0:    value = 17'd0;
                3'd1:    value = dwm_pkg::MIX_ONE;
                3'd2:    value = CFG_W'($urandom_range(65537, 131071));
                default: value = CFG_W'($urandom_range(0, 65536));
            endcase
            apply_write(dwm_pkg::REG_WET_MIX, value);
            if (phase == 1)
                pressure_go = 1'b1;
            repeat (PHASE_ITEMS) offer_item(random_item(), 1'b0, S_ZERO);
        end
        mix_req.valid <= 1'b0;

        while (pending_mixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("dry_wet_mixer_with_latency_delay_core_test OK");
        else
            $display("dry_wet_mixer_with_latency_delay_core_test NOT OK");
        $finish;
    end

endmodule
